>>> hw/rtl/grid_neighbour_mine_count_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the grid neighbour mine count unit
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef GRID_NEIGHBOUR_MINE_COUNT_UNIT_MACROS_SVH
`define GRID_NEIGHBOUR_MINE_COUNT_UNIT_MACROS_SVH

// same-cycle implication
`define GNMC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GNMC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/gnmc_pkg.sv
// ----------------------------------------------------------------------------
// gnmc_pkg
// Constants, types and the neighbour count function of the mine count unit.
// ----------------------------------------------------------------------------
package gnmc_pkg;

  localparam int MaxWidthDef  = 1024;
  localparam int MaxHeightDef = 1024;

  localparam int CfgDataW = 11;
  localparam int CfgIdxW  = 2;
  localparam int CountW   = 4;

  localparam logic [CfgIdxW-1:0] RegGridWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegGridHeight = 2'd1;

  // control of the result produced by one word in the second stage
  typedef struct packed {
    logic emit;     // word produces a result
    logic row_end;  // result for the last cell of the previous row (pre-shift window)
    logic up;       // row above the reported cell lies in the grid
    logic down;     // row below lies in the grid
    logic left;     // column to the left lies in the grid
    logic right;    // column to the right lies in the grid
    logic last;     // final cell of the grid
  } emit_ctl_t;

  // column bits: [0] top, [1] middle, [2] bottom
  function automatic logic [CountW-1:0] count_neighbours(
    input logic [2:0] centre_col,
    input logic [2:0] left_col,
    input logic [2:0] right_col,
    input emit_ctl_t  ctl
  );
    logic [CountW-1:0] acc;
    acc = '0;
    acc = acc + {3'b0, centre_col[0] & ctl.up};
    acc = acc + {3'b0, centre_col[2] & ctl.down};
    acc = acc + {3'b0, left_col[0] & ctl.left & ctl.up};
    acc = acc + {3'b0, left_col[1] & ctl.left};
    acc = acc + {3'b0, left_col[2] & ctl.left & ctl.down};
    acc = acc + {3'b0, right_col[0] & ctl.right & ctl.up};
    acc = acc + {3'b0, right_col[1] & ctl.right};
    acc = acc + {3'b0, right_col[2] & ctl.right & ctl.down};
    if (centre_col[1]) begin
      acc = '0;
    end
    return acc;
  endfunction

endpackage

>>> hw/rtl/grid_neighbour_mine_count_unit.sv
// ----------------------------------------------------------------------------
// grid_neighbour_mine_count_unit
// Minesweeper 3x3 neighbour count over a raster stream of grid cells.
// ----------------------------------------------------------------------------
// Takes one cell word per clock in raster order and returns, per cell, its
// mine flag and the number of mines among its eight neighbours (0 for a mine
// cell); cells outside the grid count as empty. A result leaves one row plus
// one cell after its cell went in, so after a grid of grid_width x
// grid_height cells the source sends grid_width + 1 pad words to flush it.
// Rate is one word per clock unless stalled; the two-stage path is a read of
// the line buffer (one 2-bit entry per column, holding the two previous
// rows) followed by a read-modify-write of that entry, with forwarding when
// the same column is touched on consecutive words (grid_width of one). The
// line buffer needs no clearing pass after reset: entries not yet written in
// a frame only feed neighbours that lie outside the grid. A register write
// restarts the frame; write registers only while the unit is idle.
module grid_neighbour_mine_count_unit
  import gnmc_pkg::*;
#(
  parameter int MAX_WIDTH  = MaxWidthDef,
  parameter int MAX_HEIGHT = MaxHeightDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                cmd_i,
  input  logic                is_mine_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                cell_is_mine_o,
  output logic [CountW-1:0]   mine_count_o,
  output logic                last_of_frame_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  `include "grid_neighbour_mine_count_unit_macros.svh"

  localparam int ColW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WDimW = $clog2(MAX_WIDTH + 1);
  localparam int HDimW = $clog2(MAX_HEIGHT + 1);
  localparam int RowW  = $clog2(MAX_HEIGHT + 2);

  // configuration
  logic [WDimW-1:0] width_q, width_d;
  logic [HDimW-1:0] height_q, height_d;
  logic             cfg_we;
  logic             cfg_restart;

  // first stage position counters
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;

  // second stage
  logic            s1_valid_q;
  logic [ColW-1:0] s1_col_q;
  logic            s1_newbit_q;
  emit_ctl_t       s1_ctl_q;

  // line buffer: [1] row above, [0] two rows above
  logic [1:0] line_mem [MAX_WIDTH];
  logic [1:0] rd_q;
  logic       fwd_q;
  logic [1:0] fwd_data_q;

  logic [8:0] window_q;

  logic              out_valid_q;
  logic              out_mine_q;
  logic [CountW-1:0] out_count_q;
  logic              out_last_q;

  logic            out_free, s1_go, advance, accept;
  logic [ColW-1:0] c_eff;
  logic [WDimW-1:0] c_inc;
  logic [RowW-1:0] h_ext;
  emit_ctl_t       ctl;
  logic            newbit;
  logic [1:0]      line_rd, wr_data;
  logic [8:0]      win_shift, win_sel;
  logic [2:0]      centre_col, left_col, right_col;
  logic [CountW-1:0] count;

  // ---------------- configuration ----------------
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;
  // only the listed registers restart the frame
  assign cfg_restart = cfg_we &&
                       ((cfg_index_i == RegGridWidth) || (cfg_index_i == RegGridHeight));

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_we) begin
      unique case (cfg_index_i)
        RegGridWidth: begin
          if (cfg_data_i == '0) begin
            width_d = WDimW'(1);
          end else if (int'(cfg_data_i) > MAX_WIDTH) begin
            width_d = WDimW'(MAX_WIDTH);
          end else begin
            width_d = WDimW'(cfg_data_i);
          end
        end
        RegGridHeight: begin
          if (cfg_data_i == '0) begin
            height_d = HDimW'(1);
          end else if (int'(cfg_data_i) > MAX_HEIGHT) begin
            height_d = HDimW'(MAX_HEIGHT);
          end else begin
            height_d = HDimW'(cfg_data_i);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WDimW'((MaxWidthDef > MAX_WIDTH) ? MAX_WIDTH : MaxWidthDef);
      height_q <= HDimW'((MaxHeightDef > MAX_HEIGHT) ? MAX_HEIGHT : MaxHeightDef);
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  // ---------------- handshake ----------------
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_go      = s1_valid_q && (!s1_ctl_q.emit || out_free);
  assign advance    = !s1_valid_q || s1_go;
  assign in_stall_o = !advance;
  assign accept     = in_valid_i && advance;

  // ---------------- first stage: position, result masks ----------------
  assign h_ext  = RowW'(height_q);
  assign newbit = !cmd_i && is_mine_i;

  always_comb begin
    c_eff = (WDimW'(col_q) >= width_q) ? '0 : col_q;
    c_inc = WDimW'(c_eff) + WDimW'(1);

    ctl         = '0;
    ctl.row_end = (c_eff == '0) && (row_q >= RowW'(2));
    ctl.emit    = ctl.row_end || ((c_eff != '0) && (row_q >= RowW'(1)));
    if (ctl.row_end) begin
      ctl.up    = row_q >= RowW'(3);
      ctl.down  = row_q <= h_ext;
      ctl.left  = width_q >= WDimW'(2);
      ctl.right = 1'b0;
      ctl.last  = row_q == (h_ext + RowW'(1));
    end else begin
      // mid-row results never reach the last column, so never the final cell
      ctl.up    = row_q >= RowW'(2);
      ctl.down  = row_q < h_ext;
      ctl.left  = c_eff >= ColW'(2);
      ctl.right = 1'b1;
      ctl.last  = 1'b0;
    end

    // advance raster position; the last result restarts the frame
    if (c_inc >= width_q) begin
      col_d = '0;
      row_d = row_q + RowW'(1);
    end else begin
      col_d = ColW'(c_inc);
      row_d = row_q;
    end
    if (ctl.emit && ctl.last) begin
      col_d = '0;
      row_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cfg_restart) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_col_q    <= c_eff;
      s1_newbit_q <= newbit;
      s1_ctl_q    <= ctl;
      // same entry written this cycle: take the new data instead of the read
      fwd_q       <= s1_go && (s1_col_q == c_eff);
      fwd_data_q  <= wr_data;
    end
  end

  // ---------------- line buffer memory ----------------
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q <= line_mem[c_eff];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      line_mem[s1_col_q] <= wr_data;
    end
  end

  // ---------------- second stage: window shift and count ----------------
  assign line_rd   = fwd_q ? fwd_data_q : rd_q;
  assign wr_data   = {s1_newbit_q, line_rd[1]};
  assign win_shift = {s1_newbit_q, line_rd[1], line_rd[0], window_q[8:3]};

  always_comb begin
    win_sel    = s1_ctl_q.row_end ? window_q : win_shift;
    centre_col = s1_ctl_q.row_end ? win_sel[8:6] : win_sel[5:3];
    left_col   = s1_ctl_q.row_end ? win_sel[5:3] : win_sel[2:0];
    right_col  = win_sel[8:6];
    count      = count_neighbours(centre_col, left_col, right_col, s1_ctl_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
    end else if (cfg_restart) begin
      window_q <= '0;
    end else if (s1_go) begin
      window_q <= (s1_ctl_q.emit && s1_ctl_q.last) ? '0 : win_shift;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_go && s1_ctl_q.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_ctl_q.emit) begin
      out_mine_q  <= centre_col[1];
      out_count_q <= count;
      out_last_q  <= s1_ctl_q.last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign cell_is_mine_o  = out_mine_q;
  assign mine_count_o    = out_count_q;
  assign last_of_frame_o = out_last_q;

  // ---------------- assertions ----------------
  `GNMC_ASSERT_NOW(a_count_range, out_valid_o,
    (mine_count_o <= CountW'(8)) && (!cell_is_mine_o || (mine_count_o == '0)),
    "mine count out of range or nonzero for a mine cell")
  `GNMC_ASSERT_NEXT(a_window_restart, s1_go && s1_ctl_q.emit && s1_ctl_q.last,
    window_q == '0, "window not cleared after last cell of grid")
  `GNMC_ASSERT_NEXT(a_pos_restart, accept && ctl.emit && ctl.last && !cfg_we,
    (col_q == '0) && (row_q == '0), "position not restarted after last cell")

endmodule
